// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define BCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// condition never holds
`define BCR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define BCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BCR_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/bcr_pkg.sv =====
// shared types and constants of the braille canvas renderer
package bcr_pkg;

  // operation codes carried in the input item
  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_GET    = 2'd1,
    OP_FILL   = 2'd2,
    OP_RENDER = 2'd3
  } op_e;

  // register index taken from the configuration address
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_e;

  // cells emitted per rendered row at most
  localparam int unsigned MAX_CELLS = 32;

  // utf-8 bytes of the braille block
  localparam logic [7:0] BYTE_LEAD     = 8'hE2;
  localparam logic [7:0] BYTE_MID_BASE = 8'hA0;
  localparam logic [7:0] BYTE_FIN_BASE = 8'h80;

  // register reset values
  localparam logic [6:0] WIDTH_RESET  = 7'd64;
  localparam logic [6:0] HEIGHT_RESET = 7'd64;

endpackage

// ===== rtl/bcr_front.sv =====
// front end: accepts items, checks bounds, computes store addresses
module bcr_front #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  localparam int unsigned AW    = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned CMD_W = 2 * AW + 5
) (
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // pos_x[15:0], pos_y[31:16], color[32], text_row[36:33], zero fill
  input  logic [39:0]      s_axis_tdata_i,
  // mode[1:0]
  input  logic [1:0]       s_axis_tuser_i,
  input  logic [WW-1:0]    w_use_i,
  input  logic [HW-1:0]    h_use_i,
  input  logic             clearing_i,
  input  logic             q_full_i,
  output logic             cmd_push_o,
  output logic [CMD_W-1:0] cmd_data_o
);

  typedef struct packed {
    bcr_pkg::op_e  op;
    logic          color;
    logic          hit;
    logic [AW-1:0] addr;
    logic [AW:0]   span;
  } cmd_t;

  logic [15:0]   pos_x;
  logic [15:0]   pos_y;
  logic          color;
  logic [3:0]    text_row;
  bcr_pkg::op_e  op;
  logic          in_bounds;
  logic          row_ok;
  logic [5:0]    row_y0;
  logic          keep;
  logic [HW-1:0] y_mul;
  logic [WW-1:0] x_add;
  logic [AW:0]   prod;
  logic [AW:0]   sum;
  cmd_t          cmd;

  // field unpacking
  assign pos_x    = s_axis_tdata_i[15:0];
  assign pos_y    = s_axis_tdata_i[31:16];
  assign color    = s_axis_tdata_i[32];
  assign text_row = s_axis_tdata_i[36:33];
  assign op       = bcr_pkg::op_e'(s_axis_tuser_i);

  // bounds checks
  assign in_bounds = !pos_x[15] && (pos_x < 16'(w_use_i)) &&
                     !pos_y[15] && (pos_y < 16'(h_use_i));
  assign row_y0 = {text_row, 2'b00};
  assign row_ok = 16'(row_y0) < 16'(h_use_i);

  // operand select for the shared row multiplier
  always_comb begin
    y_mul = pos_y[HW-1:0];
    x_add = pos_x[WW-1:0];
    keep  = 1'b1;
    unique case (op)
      bcr_pkg::OP_SET: begin
        keep = in_bounds;
      end
      bcr_pkg::OP_GET: begin
        keep = 1'b1;
      end
      bcr_pkg::OP_FILL: begin
        y_mul = h_use_i;
        x_add = '0;
      end
      bcr_pkg::OP_RENDER: begin
        y_mul = HW'(row_y0);
        x_add = '0;
        keep  = row_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // row times width plus column, or the fill span
  assign prod = (AW + 1)'(y_mul) * (AW + 1)'(w_use_i);
  assign sum  = prod + (AW + 1)'(x_add);

  always_comb begin
    cmd.op    = op;
    cmd.color = color;
    cmd.hit   = in_bounds;
    cmd.addr  = sum[AW-1:0];
    cmd.span  = sum;
  end

  // handshake: dropped items are taken but never queued
  assign s_axis_tready_o = !q_full_i && !clearing_i;
  assign cmd_push_o      = s_axis_tvalid_i && s_axis_tready_o && keep;
  assign cmd_data_o      = cmd;

endmodule

// ===== rtl/bcr_queue.sv =====
// short command queue between front end and back end
module bcr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o     = count_q == CW'(DEPTH);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/bcr_back.sv =====
// back end: pixel memory, fill and clear sweeps, read sequencer, output register
module bcr_back #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int unsigned AW    = $clog2(DEPTH),
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1),
  localparam int unsigned CMD_W = 2 * AW + 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WW-1:0]    w_use_i,
  input  logic             cmd_valid_i,
  input  logic [CMD_W-1:0] cmd_data_i,
  output logic             cmd_pop_o,
  output logic             clearing_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // pixel_value[0], lead_byte[8:1], middle_byte[16:9], final_byte[24:17], zero fill
  output logic [31:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  localparam int unsigned CW = $clog2(bcr_pkg::MAX_CELLS);

  typedef struct packed {
    bcr_pkg::op_e  op;
    logic          color;
    logic          hit;
    logic [AW-1:0] addr;
    logic [AW:0]   span;
  } cmd_t;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_FILL  = 6'b000100,
    ST_READ  = 6'b001000,
    ST_LAND  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  // dot bit of the pixel at column offset dx, row offset dy, index {dx, dy}
  function automatic logic [2:0] dot_pos(input logic [2:0] idx);
    logic [2:0] pos;
    case (idx)
      3'b000:  pos = 3'd0;
      3'b001:  pos = 3'd1;
      3'b010:  pos = 3'd2;
      3'b011:  pos = 3'd6;
      3'b100:  pos = 3'd3;
      3'b101:  pos = 3'd4;
      3'b110:  pos = 3'd5;
      default: pos = 3'd7;
    endcase
    return pos;
  endfunction

  cmd_t          cmd;
  state_e        state_q, state_d;
  logic [AW:0]   ptr_q, ptr_d;
  logic [AW:0]   end_q, end_d;
  logic          color_q, color_d;
  logic          get_q, get_d;
  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] cell_q, cell_d;
  logic [2:0]    dot_q, dot_d;
  logic [7:0]    dots_q;
  logic          dots_clr;
  logic          rd_vld_q;
  logic [2:0]    rd_dot_q;
  logic          rdata_q;
  logic          out_valid_q;
  logic [31:0]   out_data_q;
  logic          out_last_q;
  logic          mem_q [DEPTH];

  logic          we;
  logic [AW-1:0] waddr;
  logic          wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [AW:0]   w_ext;
  logic [AW:0]   dy_off;
  logic [WW-1:0] half_w;
  logic [CW-1:0] cells_m1;
  logic          last_cell;
  logic          out_free;
  logic          emit;
  logic [31:0]   emit_data;
  logic [7:0]    mid_byte;
  logic [7:0]    fin_byte;

  assign cmd = cmd_t'(cmd_data_i);

  // cell count of a row, capped
  assign half_w = w_use_i >> 1;
  always_comb begin
    if (32'(half_w) > bcr_pkg::MAX_CELLS) begin
      cells_m1 = CW'(bcr_pkg::MAX_CELLS - 1);
    end else begin
      cells_m1 = CW'(half_w - 1'b1);
    end
  end
  assign last_cell = cell_q == cells_m1;

  // read address: row base plus dy rows plus 2*cell plus dx
  assign w_ext = (AW + 1)'(w_use_i);
  always_comb begin
    case (dot_q[1:0])
      2'd0:    dy_off = '0;
      2'd1:    dy_off = w_ext;
      2'd2:    dy_off = w_ext << 1;
      default: dy_off = w_ext + (w_ext << 1);
    endcase
  end
  assign raddr = AW'((AW + 1)'(base_q) + dy_off + (AW + 1)'({cell_q, dot_q[2]}));

  // output register frees when empty or being taken
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign emit     = (state_q == ST_EMIT) && out_free;

  // sequencer
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    end_d     = end_q;
    color_d   = color_q;
    get_d     = get_q;
    base_d    = base_q;
    cell_d    = cell_q;
    dot_d     = dot_q;
    dots_clr  = 1'b0;
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    waddr     = ptr_q[AW-1:0];
    wdata     = 1'b0;
    re        = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q[AW-1:0] == AW'(DEPTH - 1)) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i) begin
          case (cmd.op)
            bcr_pkg::OP_SET: begin
              we    = 1'b1;
              waddr = cmd.addr;
              wdata = cmd.color;
            end
            bcr_pkg::OP_GET: begin
              get_d  = 1'b1;
              base_d = cmd.addr;
              cell_d = '0;
              dot_d  = '0;
              if (cmd.hit) begin
                state_d = ST_READ;
              end else begin
                dots_clr = 1'b1;
                state_d  = ST_EMIT;
              end
            end
            bcr_pkg::OP_FILL: begin
              ptr_d   = '0;
              end_d   = cmd.span;
              color_d = cmd.color;
              state_d = ST_FILL;
            end
            default: begin
              get_d   = 1'b0;
              base_d  = cmd.addr;
              cell_d  = '0;
              dot_d   = '0;
              state_d = ST_READ;
            end
          endcase
        end
      end
      ST_FILL: begin
        we    = 1'b1;
        wdata = color_q;
        ptr_d = ptr_q + 1'b1;
        if (ptr_d == end_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        re    = 1'b1;
        dot_d = dot_q + 1'b1;
        if (get_q || dot_q == 3'd7) begin
          state_d = ST_LAND;
        end
      end
      ST_LAND: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (get_q || last_cell) begin
            state_d = ST_IDLE;
          end else begin
            cell_d  = cell_q + 1'b1;
            dot_d   = '0;
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      end_q       <= '0;
      get_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      end_q    <= end_d;
      get_q    <= get_d;
      rd_vld_q <= re;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload of the sequencer
  always_ff @(posedge clk_i) begin
    color_q  <= color_d;
    base_q   <= base_d;
    cell_q   <= cell_d;
    dot_q    <= dot_d;
    rd_dot_q <= dot_q;
    if (dots_clr) begin
      dots_q <= '0;
    end else if (rd_vld_q) begin
      dots_q[dot_pos(rd_dot_q)] <= rdata_q;
    end
  end

  // pixel memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // result item build
  assign mid_byte = bcr_pkg::BYTE_MID_BASE | {6'b0, dots_q[7], dots_q[6]};
  assign fin_byte = bcr_pkg::BYTE_FIN_BASE | {2'b0, dots_q[5:0]};
  always_comb begin
    if (get_q) begin
      emit_data = {31'b0, dots_q[0]};
    end else begin
      emit_data = {7'b0, fin_byte, mid_byte, bcr_pkg::BYTE_LEAD, 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= emit_data;
      out_last_q <= !get_q && last_cell;
    end
  end

  assign clearing_o      = state_q == ST_CLEAR;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== rtl/braille_canvas_renderer_core.sv =====
// Braille canvas renderer: a one-bit pixel canvas of MAX_WIDTH*MAX_HEIGHT pixels kept in a
// single-port-write, single-port-read memory; after reset the block sweeps the whole memory to
// black with s_axis_tready low. In the back end a set item is a single write, a get a single
// pixel read (none when off the canvas), a fill a write of each of the w*h pixels in use, and a
// render per cell eight pixel reads through the one memory read port, then the landing of the
// last read, then the load of the output register; a stall on the result side holds it. A two-entry
// queue lets the front end keep taking items while the back end works.
`include "assert_macros.svh"

module braille_canvas_renderer_core #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[15:0], pos_y[31:16], color[32], text_row[36:33], zero fill
  input  logic [39:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_value[0], lead_byte[8:1], middle_byte[16:9], final_byte[24:17], zero fill
  output logic [31:0] m_axis_tdata,
  // last_cell
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CMD_W = 2 * AW + 5;

  logic [6:0]       width_q;
  logic [6:0]       height_q;
  logic             cfg_wr;
  logic [WW-1:0]    w_sat;
  logic [WW-1:0]    w_use;
  logic [HW-1:0]    h_sat;
  logic [HW-1:0]    h_use;
  logic             clearing;
  logic             q_full;
  logic             q_empty;
  logic             cmd_push;
  logic             cmd_pop;
  logic [CMD_W-1:0] cmd_in;
  logic [CMD_W-1:0] cmd_out;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bcr_pkg::WIDTH_RESET;
      height_q <= bcr_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (bcr_pkg::reg_e'(paddr[2]))
        bcr_pkg::REG_WIDTH:  width_q  <= pwdata[6:0];
        bcr_pkg::REG_HEIGHT: height_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (bcr_pkg::reg_e'(paddr[2]))
      bcr_pkg::REG_WIDTH:  prdata = {25'b0, width_q};
      bcr_pkg::REG_HEIGHT: prdata = {25'b0, height_q};
      default:             prdata = '0;
    endcase
  end

  // size in use: saturate, then round down to the cell grid
  always_comb begin
    if (32'(width_q) > MAX_WIDTH) begin
      w_sat = WW'(MAX_WIDTH);
    end else if (width_q < 7'd2) begin
      w_sat = WW'(2);
    end else begin
      w_sat = WW'(width_q);
    end
    if (32'(height_q) > MAX_HEIGHT) begin
      h_sat = HW'(MAX_HEIGHT);
    end else if (height_q < 7'd4) begin
      h_sat = HW'(4);
    end else begin
      h_sat = HW'(height_q);
    end
  end
  assign w_use = w_sat & ~WW'(1);
  assign h_use = h_sat & ~HW'(3);

  // front end
  bcr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .w_use_i         (w_use),
    .h_use_i         (h_use),
    .clearing_i      (clearing),
    .q_full_i        (q_full),
    .cmd_push_o      (cmd_push),
    .cmd_data_o      (cmd_in)
  );

  // command queue
  bcr_queue #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_in),
    .pop_i       (cmd_pop),
    .pop_data_o  (cmd_out),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // back end
  bcr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .w_use_i         (w_use),
    .cmd_valid_i     (!q_empty),
    .cmd_data_i      (cmd_out),
    .cmd_pop_o       (cmd_pop),
    .clearing_o      (clearing),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  // checks
  `BCR_ASSERT_IMPL(a_no_accept_clear, clk_i, rst_ni, clearing, !s_axis_tready)
  `BCR_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, cmd_push, !q_full)
  `BCR_ASSERT_IMPL(a_clear_ends_empty, clk_i, rst_ni, $fell(clearing), q_empty)
  `BCR_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, cmd_pop && q_empty)

endmodule

// ===== verif/tb_braille_canvas_renderer_core.sv =====
// testbench for the braille canvas renderer core: random and directed items, canvas predictor
`timescale 1ns / 1ps

module tb_braille_canvas_renderer_core;

  localparam int unsigned CANVAS_MAX_W  = 64;
  localparam int unsigned CANVAS_MAX_H  = 64;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned HOLD_CYCLES   = 800;
  localparam int unsigned RUN_LIMIT     = 5000000;

  // one input item as the block sees it
  typedef struct packed {
    bcr_pkg::op_e mode;
    logic [15:0]  pos_x;
    logic [15:0]  pos_y;
    logic         color;
    logic [3:0]   text_row;
  } canvas_item_t;

  // one result item
  typedef struct packed {
    logic       pixel_value;
    logic [7:0] lead_byte;
    logic [7:0] middle_byte;
    logic [7:0] final_byte;
    logic       last_cell;
  } cell_result_t;

  // canvas predictor with the queue of cells still owed by the block
  class canvas_tracker;
    bit           pixels [CANVAS_MAX_W * CANVAS_MAX_H];
    logic [6:0]   width_reg = bcr_pkg::WIDTH_RESET;
    logic [6:0]   height_reg = bcr_pkg::HEIGHT_RESET;
    cell_result_t owed_cells [$];
    int unsigned  errors = 0;

    function void set_register(bcr_pkg::reg_e idx, logic [6:0] value);
      if (idx == bcr_pkg::REG_WIDTH) width_reg = value;
      else height_reg = value;
    endfunction

    // width in use: saturated, then even
    function int unsigned width_used();
      int unsigned w;
      w = width_reg;
      if (w > CANVAS_MAX_W) w = CANVAS_MAX_W;
      if (w < 2) w = 2;
      return w & ~32'd1;
    endfunction

    // height in use: saturated, then a multiple of four
    function int unsigned height_used();
      int unsigned h;
      h = height_reg;
      if (h > CANVAS_MAX_H) h = CANVAS_MAX_H;
      if (h < 4) h = 4;
      return h & ~32'd3;
    endfunction

    function bit pixel_at(int unsigned x, int unsigned y, int unsigned w);
      return pixels[y * w + x];
    endfunction

    function int unsigned pending();
      return owed_cells.size();
    endfunction

    // apply one accepted item and queue the cells it causes
    function void note_item(canvas_item_t it);
      int unsigned  w, h, y0, x0, cells;
      int           x, y;
      bit           on_canvas;
      logic [7:0]   dots;
      cell_result_t res;
      w = width_used();
      h = height_used();
      x = $signed(it.pos_x);
      y = $signed(it.pos_y);
      on_canvas = (x >= 0) && (y >= 0) && (x < int'(w)) && (y < int'(h));
      case (it.mode)
        bcr_pkg::OP_SET: begin
          if (on_canvas) pixels[y * w + x] = it.color;
        end
        bcr_pkg::OP_GET: begin
          res = '0;
          res.pixel_value = on_canvas ? pixel_at(x, y, w) : 1'b0;
          owed_cells.push_back(res);
        end
        bcr_pkg::OP_FILL: begin
          for (int unsigned i = 0; i < w * h; i++) pixels[i] = it.color;
        end
        default: begin
          // render: rows past the canvas give nothing
          y0 = it.text_row * 4;
          if (y0 < h) begin
            cells = w / 2;
            if (cells > bcr_pkg::MAX_CELLS) cells = bcr_pkg::MAX_CELLS;
            for (int unsigned k = 0; k < cells; k++) begin
              x0 = 2 * k;
              dots = {pixel_at(x0 + 1, y0 + 3, w), pixel_at(x0, y0 + 3, w),
                      pixel_at(x0 + 1, y0 + 2, w), pixel_at(x0 + 1, y0 + 1, w),
                      pixel_at(x0 + 1, y0, w), pixel_at(x0, y0 + 2, w),
                      pixel_at(x0, y0 + 1, w), pixel_at(x0, y0, w)};
              res.pixel_value = 1'b0;
              res.lead_byte = bcr_pkg::BYTE_LEAD;
              res.middle_byte = bcr_pkg::BYTE_MID_BASE | {6'd0, dots[7], dots[6]};
              res.final_byte = bcr_pkg::BYTE_FIN_BASE | {2'd0, dots[5:0]};
              res.last_cell = (k == cells - 1);
              owed_cells.push_back(res);
            end
          end
        end
      endcase
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    // check one result item against the oldest owed cell
    function void check_cell(logic [31:0] data, logic last);
      cell_result_t want;
      if (owed_cells.size() == 0) begin
        $display("%0t: unexpected result, expected none, got tdata %0h tlast %0b",
                 $time, data, last);
        errors++;
        return;
      end
      want = owed_cells.pop_front();
      compare("pixel_value", want.pixel_value, data[0]);
      compare("lead_byte", want.lead_byte, data[8:1]);
      compare("middle_byte", want.middle_byte, data[16:9]);
      compare("final_byte", want.final_byte, data[24:17]);
      compare("last_cell", want.last_cell, last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  canvas_tracker tracker = new;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   holds_asked = 0;
  int unsigned   holds_served = 0;
  int unsigned   hold_left = 0;
  int unsigned   cycle_count = 0;

  braille_canvas_renderer_core #(
    .MAX_WIDTH  (CANVAS_MAX_W),
    .MAX_HEIGHT (CANVAS_MAX_H)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: check accepted items, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_cell(m_axis_tdata, m_axis_tlast);
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (holds_asked != holds_served) begin
      // long hold-off so the block backs up into its input
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // register write through setup and access cycles
  task automatic write_reg(bcr_pkg::reg_e idx, logic [6:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {25'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_register(idx, value);
  endtask

  // offer one item, with random idle cycles ahead of it
  task automatic offer_item(bcr_pkg::op_e mode, int x, int y, bit color, int row);
    canvas_item_t it;
    it.mode = mode;
    it.pos_x = x[15:0];
    it.pos_y = y[15:0];
    it.color = color;
    it.text_row = row[3:0];
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.mode;
    s_axis_tdata <= {3'd0, it.text_row, it.color, it.pos_y, it.pos_x};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_item(it);
  endtask

  // wait until every owed cell has come back, then let the block settle
  task automatic wait_idle();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one configuration followed by random items, closed by a get
  task automatic run_phase(logic [6:0] width_val, logic [6:0] height_val, int unsigned count,
                           int unsigned idle_pct, int unsigned stall_pct, bit hold);
    int unsigned  w, h, pick;
    int           x, y, row;
    bcr_pkg::op_e mode;
    write_reg(bcr_pkg::REG_WIDTH, width_val);
    write_reg(bcr_pkg::REG_HEIGHT, height_val);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    if (hold) holds_asked <= holds_asked + 1;
    w = tracker.width_used();
    h = tracker.height_used();
    repeat (count) begin
      pick = $urandom_range(99);
      mode = (pick < 40) ? bcr_pkg::OP_SET : (pick < 65) ? bcr_pkg::OP_GET :
             (pick < 70) ? bcr_pkg::OP_FILL : bcr_pkg::OP_RENDER;
      // mostly on the canvas, some just off its edges, some anywhere
      case ($urandom_range(9))
        0: x = $urandom_range(65535);
        1: x = $urandom_range(1) ? -1 : int'(w);
        default: x = $urandom_range(w - 1);
      endcase
      case ($urandom_range(9))
        0: y = $urandom_range(65535);
        1: y = $urandom_range(1) ? -1 : int'(h);
        default: y = $urandom_range(h - 1);
      endcase
      if (mode == bcr_pkg::OP_RENDER && $urandom_range(9) < 7) row = $urandom_range(h / 4 - 1);
      else row = $urandom_range(15);
      offer_item(mode, x, y, 1'($urandom_range(1)), row);
    end
    offer_item(bcr_pkg::OP_GET, $urandom_range(w - 1), $urandom_range(h - 1),
               1'($urandom_range(1)), $urandom_range(15));
    s_axis_tvalid <= 1'b0;
    wait_idle();
  endtask

  // stimulus
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items on the reset canvas size
    offer_item(bcr_pkg::OP_SET, 0, 0, 1'b1, 0);
    offer_item(bcr_pkg::OP_SET, 63, 63, 1'b1, 15);
    offer_item(bcr_pkg::OP_SET, 1, 3, 1'b1, 0);
    offer_item(bcr_pkg::OP_SET, -1, 0, 1'b1, 0);
    offer_item(bcr_pkg::OP_SET, 64, 5, 1'b1, 0);
    offer_item(bcr_pkg::OP_SET, -32768, 32767, 1'b1, 0);
    offer_item(bcr_pkg::OP_SET, 32767, -32768, 1'b1, 15);
    offer_item(bcr_pkg::OP_GET, 0, 0, 1'b0, 0);
    offer_item(bcr_pkg::OP_GET, 63, 63, 1'b0, 0);
    offer_item(bcr_pkg::OP_GET, 1, 3, 1'b1, 0);
    offer_item(bcr_pkg::OP_GET, -1, 0, 1'b0, 0);
    offer_item(bcr_pkg::OP_GET, 0, 64, 1'b0, 0);
    offer_item(bcr_pkg::OP_GET, 32767, 32767, 1'b0, 15);
    offer_item(bcr_pkg::OP_GET, -32768, -32768, 1'b0, 0);
    offer_item(bcr_pkg::OP_RENDER, 0, 0, 1'b0, 0);
    offer_item(bcr_pkg::OP_RENDER, 0, 0, 1'b0, 15);
    offer_item(bcr_pkg::OP_FILL, 0, 0, 1'b1, 0);
    offer_item(bcr_pkg::OP_RENDER, 0, 0, 1'b0, 3);
    offer_item(bcr_pkg::OP_GET, 40, 20, 1'b0, 0);
    offer_item(bcr_pkg::OP_SET, 40, 20, 1'b0, 0);
    offer_item(bcr_pkg::OP_RENDER, 0, 0, 1'b0, 5);
    offer_item(bcr_pkg::OP_FILL, 0, 0, 1'b0, 0);
    offer_item(bcr_pkg::OP_GET, 40, 21, 1'b0, 0);
    offer_item(bcr_pkg::OP_RENDER, 0, 0, 1'b0, 0);
    s_axis_tvalid <= 1'b0;
    wait_idle();

    // random phases over several canvas sizes, extremes and out-of-range values included
    run_phase(7'd2, 7'd4, 50, 48, 0, 1'b0);
    run_phase(7'd127, 7'd127, 80, 0, 48, 1'b1);
    run_phase(7'd0, 7'd0, 30, 10, 10, 1'b0);
    run_phase(7'd7, 7'd9, 50, 10, 10, 1'b0);
    run_phase(7'd20, 7'd12, 60, 0, 0, 1'b0);
    run_phase(7'd33, 7'd63, 60, 48, 0, 1'b0);
    run_phase(7'd64, 7'd64, 60, 0, 48, 1'b0);
    run_phase(7'd1, 7'd3, 30, 10, 10, 1'b0);

    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
